[hw/rtl/fslf_pkg.sv]
// Package for the fixed-string line filter: word types, configuration
// register indexes and default parameter values. No dependencies.
`default_nettype none

package fslf_pkg;

  localparam int PATTERN_BYTES_DEF = 8;
  localparam int LINE_LIMIT_DEF    = 1024;
  localparam int CFG_INDEX_W       = 2;
  localparam int CFG_DATA_W        = 64;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERT  = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [31:0] line_number;
    logic        contains_pattern;
    logic        selected;
    logic [31:0] selected_count;
  } out_word_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } fslf_tap_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } fslf_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/fixed_string_line_filter_core.sv]
// Fixed-string line filter: one byte word per cycle while in_stall is low, one
// result word per line; the window cells compare all pattern bytes in parallel.
// A line's result goes to the output register, or to the skid stage while the
// output stalls, once its newline or end-of-stream word is accepted.
// Reset (synchronous, active low) clears configuration, line state and
// counters; the output register and skid stage come up empty.
`default_nettype none

module fixed_string_line_filter_core
  import fslf_pkg::*;
#(
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
  parameter int LINE_LIMIT    = LINE_LIMIT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  in_word_t                    in_word,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_word_t                   out_word,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int POS_W = $clog2(LINE_LIMIT + 1);
  localparam logic [POS_W-1:0] POS_MAX  = POS_W'(LINE_LIMIT);
  localparam logic [POS_W-1:0] EXAM_MAX = POS_W'(LINE_LIMIT - 1);
  localparam logic [3:0]       PB_LEN   = 4'(PATTERN_BYTES);

  logic [63:0]      pattern_r;
  logic [3:0]       length_r;
  logic             invert_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             match_r, match_nxt;
  logic             zero_r, zero_nxt;
  logic [31:0]      lines_r, lines_nxt;
  logic [31:0]      sel_cnt_r, sel_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  out_word_t        skid_word_r, skid_word_nxt;

  logic             accept;
  logic             in_line;
  logic             examine;
  logic             zero_hit;
  logic             line_end;
  logic             hit_now;
  logic             contains;
  logic             sel;
  logic [3:0]       used_len;
  out_word_t        result;
  fslf_ctl_t        ctl;

  fslf_tap_t              head_tap;
  fslf_tap_t              cell_q [PATTERN_BYTES];
  logic [PATTERN_BYTES-1:0] hit_vec;
  logic [PATTERN_BYTES-1:0] cmp_en;
  logic [7:0]             expect_b [PATTERN_BYTES];

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign accept   = in_valid && !in_stall;
  assign used_len = (length_r > PB_LEN) ? PB_LEN : length_r;
  assign in_line  = accept && !in_word.end_of_stream && (pos_r < EXAM_MAX) && !zero_r;
  assign examine  = in_line && (in_word.text_byte != 8'd0);
  assign zero_hit = in_line && (in_word.text_byte == 8'd0);
  assign line_end = accept && (in_word.end_of_stream ? (pos_r != '0)
                                                     : (in_word.text_byte == NEWLINE_BYTE));
  assign hit_now  = examine && (&hit_vec);
  assign contains = match_r || hit_now || (used_len == 4'd0);
  assign sel      = contains ^ invert_r;

  assign ctl.shift = examine;
  assign ctl.clear = line_end;
  assign head_tap  = '{vld: 1'b1, data: in_word.text_byte};

  for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_cell
    logic [3:0] pidx;
    assign pidx        = used_len - 4'(j + 1);
    assign cmp_en[j]   = 4'(j) < used_len;
    assign expect_b[j] = pattern_r[{pidx[2:0], 3'b000} +: 8];

    fslf_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .tap_in      ((j == 0) ? head_tap : cell_q[(j == 0) ? 0 : j - 1]),
      .expect_byte (expect_b[j]),
      .cmp_en      (cmp_en[j]),
      .tap_out     (cell_q[j]),
      .hit         (hit_vec[j])
    );
  end

  always_comb begin
    pos_nxt     = pos_r;
    match_nxt   = match_r || hit_now;
    zero_nxt    = zero_r || zero_hit;
    lines_nxt   = lines_r;
    sel_cnt_nxt = sel_cnt_r;
    if (accept && !in_word.end_of_stream && (pos_r != POS_MAX)) begin
      pos_nxt = pos_r + POS_W'(1);
    end
    if (line_end) begin
      pos_nxt   = '0;
      match_nxt = 1'b0;
      zero_nxt  = 1'b0;
      if (lines_r != 32'hFFFF_FFFF) begin
        lines_nxt = lines_r + 32'd1;
      end
      if (sel && (sel_cnt_r != 32'hFFFF_FFFF)) begin
        sel_cnt_nxt = sel_cnt_r + 32'd1;
      end
    end

    result = '{line_number: lines_nxt, contains_pattern: contains,
               selected: sel, selected_count: sel_cnt_nxt};

    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    skid_valid_nxt = skid_valid_r;
    skid_word_nxt  = skid_word_r;
    if (skid_valid_r) begin
      if (!out_stall) begin
        out_word_nxt   = skid_word_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || !out_stall) begin
      out_valid_nxt = line_end;
      out_word_nxt  = result;
    end else if (line_end) begin
      skid_valid_nxt = 1'b1;
      skid_word_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r    <= '0;
      length_r     <= '0;
      invert_r     <= 1'b0;
      pos_r        <= '0;
      match_r      <= 1'b0;
      zero_r       <= 1'b0;
      lines_r      <= '0;
      sel_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PATTERN: pattern_r <= cfg_data;
          CFG_LENGTH:  length_r  <= cfg_data[3:0];
          CFG_INVERT:  invert_r  <= cfg_data[0];
          default: ;
        endcase
      end
      pos_r        <= pos_nxt;
      match_r      <= match_nxt;
      zero_r       <= zero_nxt;
      lines_r      <= lines_nxt;
      sel_cnt_r    <= sel_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full while output register empty");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("line position beyond its limit");

  a_zero_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    zero_r |-> (pos_r != '0))
    else $error("zero byte flag set outside a line");

  a_sel_le_lines: assert property (@(posedge clk) disable iff (!rst_n)
    sel_cnt_r <= lines_r)
    else $error("selected count exceeds line count");

  a_line_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (line_end && !(out_valid_r && out_stall))
      |=> (out_valid_r && (out_word_r.line_number == lines_r)))
    else $error("finished line did not reach the output");

endmodule

`default_nettype wire

[hw/rtl/fslf_cell.sv]
// One cell of the byte window: holds one examined byte and compares the
// byte it is about to take against its pattern byte. Uses fslf_pkg.
`default_nettype none

module fslf_cell
  import fslf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  fslf_ctl_t      ctl,
  input  fslf_tap_t      tap_in,
  input  wire logic [7:0] expect_byte,
  input  wire logic      cmp_en,
  output fslf_tap_t      tap_out,
  output logic           hit
);

  logic       vld_r;
  logic [7:0] data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.clear) begin
      vld_r <= 1'b0;
    end else if (ctl.shift) begin
      vld_r <= tap_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data_r <= tap_in.data;
    end
  end

  assign tap_out = '{vld: vld_r, data: data_r};
  assign hit     = !cmp_en || (tap_in.vld && (tap_in.data == expect_byte));

endmodule

`default_nettype wire
